>>> src/assert_macros.svh
// Assertion macros used by the checker file of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge while reset is released.
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> src/lprd_pkg.sv
// Types, codes and constants of the length-prefixed request deframer.
`default_nettype none

package lprd_pkg;

	localparam int unsigned CFG_W = 13;
	localparam int unsigned IDX_W = 10;
	localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

	typedef enum logic [4:0] {
		PH_OUTER  = 5'b00001,
		PH_COUNT  = 5'b00010,
		PH_SLEN   = 5'b00100,
		PH_BODY   = 5'b01000,
		PH_CLOSED = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LONG = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_DEL     = 2'd1,
		CMD_SET     = 2'd2,
		CMD_UNKNOWN = 2'd3
	} command_t;

	// Command words, first character in the lowest byte.
	localparam logic [23:0] WORD_GET = 24'h746567;
	localparam logic [23:0] WORD_DEL = 24'h6C6564;
	localparam logic [23:0] WORD_SET = 24'h746573;

	// Match flag bits.
	localparam int unsigned MF_GET = 0;
	localparam int unsigned MF_DEL = 1;
	localparam int unsigned MF_SET = 2;
	localparam int unsigned MF_LEN3 = 3;

	typedef struct packed {
		logic             carries_byte;
		logic [7:0]       string_byte;
		logic [IDX_W-1:0] string_index;
		logic             string_done;
		logic             message_end;
		status_t          status;
		command_t         command;
		logic [IDX_W-1:0] string_count;
	} result_t;

	function automatic logic [7:0] lower_ascii(input logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	function automatic logic [7:0] word_char(input logic [23:0] word, input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0: c = word[7:0];
			2'd1: c = word[15:8];
			2'd2: c = word[23:16];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/lprd_core.sv
// Framing state and per-byte parse step of the deframer.
`default_nettype none

module lprd_core #(
	parameter int unsigned MAX_BODY_BYTES = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [7:0]                  data_byte,
	input  wire logic [lprd_pkg::CFG_W-1:0]  max_len,
	output lprd_pkg::result_t                res,
	output logic                             res_vld
);

	localparam int unsigned MBW = $clog2(MAX_BODY_BYTES + 1);

	lprd_pkg::phase_t phase_q, phase_d;
	logic [1:0]       hpos_q, hpos_d;
	logic [23:0]      hdr_q, hdr_d;
	logic [MBW-1:0]   mleft_q, mleft_d;
	logic [31:0]      sleft_q, sleft_d;
	logic [31:0]      total_q, total_d;
	logic [MBW-1:0]   sbl_q, sbl_d;
	logic [lprd_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [3:0]       flags_q, flags_d;
	logic             first_q, first_d;

	logic [31:0]      hdr_full;
	logic             hdr_done;
	logic [23:0]      hdr_ins;
	logic [MBW-1:0]   mleft_dec;
	logic [31:0]      sl_new;
	logic             item_done;
	logic [7:0]       low_c;
	logic [1:0]       cpos;

	assign hdr_full  = {data_byte, hdr_q};
	assign hdr_done  = (hpos_q == 2'd3);
	assign mleft_dec = mleft_q - MBW'(1);
	assign low_c     = lprd_pkg::lower_ascii(data_byte);
	assign cpos      = 2'd3 - sbl_q[1:0];

	always_comb begin
		hdr_ins = hdr_q;
		case (hpos_q)
			2'd0: hdr_ins[7:0] = data_byte;
			2'd1: hdr_ins[15:8] = data_byte;
			2'd2: hdr_ins[23:16] = data_byte;
			default: hdr_ins = hdr_q;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		hpos_d    = hpos_q;
		hdr_d     = hdr_q;
		mleft_d   = mleft_q;
		sleft_d   = sleft_q;
		total_d   = total_q;
		sbl_d     = sbl_q;
		idx_d     = idx_q;
		flags_d   = flags_q;
		first_d   = first_q;
		res       = '0;
		res_vld   = 1'b0;
		item_done = 1'b0;
		sl_new    = sleft_q;

		case (phase_q)
			lprd_pkg::PH_OUTER: begin
				hpos_d = hpos_q + 2'd1;
				hdr_d  = hdr_ins;
				if (hdr_done) begin
					if (hdr_full > 32'(max_len) || hdr_full > 32'(MAX_BODY_BYTES)) begin
						phase_d         = lprd_pkg::PH_CLOSED;
						res.message_end = 1'b1;
						res.status      = lprd_pkg::ST_LONG;
						res_vld         = 1'b1;
					end else if (hdr_full < 32'd4) begin
						phase_d         = lprd_pkg::PH_CLOSED;
						res.message_end = 1'b1;
						res.status      = lprd_pkg::ST_BAD;
						res_vld         = 1'b1;
					end else begin
						mleft_d = hdr_full[MBW-1:0];
						phase_d = lprd_pkg::PH_COUNT;
					end
				end
			end
			lprd_pkg::PH_COUNT: begin
				mleft_d = mleft_dec;
				hpos_d  = hpos_q + 2'd1;
				hdr_d   = hdr_ins;
				if (hdr_done) begin
					total_d   = hdr_full;
					sleft_d   = hdr_full;
					sl_new    = hdr_full;
					item_done = 1'b1;
				end
			end
			lprd_pkg::PH_SLEN: begin
				mleft_d = mleft_dec;
				hpos_d  = hpos_q + 2'd1;
				hdr_d   = hdr_ins;
				if (hdr_done) begin
					if (hdr_full > 32'(mleft_dec)) begin
						phase_d         = lprd_pkg::PH_CLOSED;
						res.message_end = 1'b1;
						res.status      = lprd_pkg::ST_BAD;
						res_vld         = 1'b1;
					end else begin
						sbl_d = hdr_full[MBW-1:0];
						if (first_q && hdr_full != 32'd3) begin
							flags_d[lprd_pkg::MF_LEN3] = 1'b0;
						end
						if (hdr_full == 32'd0) begin
							// Empty string: one mark with no byte.
							res.string_done  = 1'b1;
							res.string_index = idx_q;
							res_vld          = 1'b1;
							idx_d            = idx_q + 1'b1;
							sl_new           = sleft_q - 32'd1;
							sleft_d          = sl_new;
							first_d          = 1'b0;
							item_done        = 1'b1;
						end else begin
							phase_d = lprd_pkg::PH_BODY;
						end
					end
				end
			end
			lprd_pkg::PH_BODY: begin
				mleft_d = mleft_dec;
				if (first_q && flags_q[lprd_pkg::MF_LEN3] && sbl_q <= MBW'(3)) begin
					if (low_c != lprd_pkg::word_char(lprd_pkg::WORD_GET, cpos)) begin
						flags_d[lprd_pkg::MF_GET] = 1'b0;
					end
					if (low_c != lprd_pkg::word_char(lprd_pkg::WORD_DEL, cpos)) begin
						flags_d[lprd_pkg::MF_DEL] = 1'b0;
					end
					if (low_c != lprd_pkg::word_char(lprd_pkg::WORD_SET, cpos)) begin
						flags_d[lprd_pkg::MF_SET] = 1'b0;
					end
				end
				sbl_d            = sbl_q - MBW'(1);
				res.carries_byte = 1'b1;
				res.string_byte  = data_byte;
				res.string_index = idx_q;
				res_vld          = 1'b1;
				if (sbl_q == MBW'(1)) begin
					res.string_done = 1'b1;
					idx_d           = idx_q + 1'b1;
					sl_new          = sleft_q - 32'd1;
					sleft_d         = sl_new;
					first_d         = 1'b0;
					item_done       = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// The count or a string is complete: end the message or fetch the next header.
		if (item_done) begin
			if (sl_new == 32'd0 && mleft_dec == '0) begin
				res.message_end  = 1'b1;
				res.status       = lprd_pkg::ST_OK;
				res.string_count = total_d[lprd_pkg::IDX_W-1:0];
				res.command      = lprd_pkg::CMD_UNKNOWN;
				if (flags_d[lprd_pkg::MF_LEN3]) begin
					if (total_d == 32'd2 && flags_d[lprd_pkg::MF_GET]) begin
						res.command = lprd_pkg::CMD_GET;
					end else if (total_d == 32'd2 && flags_d[lprd_pkg::MF_DEL]) begin
						res.command = lprd_pkg::CMD_DEL;
					end else if (total_d == 32'd3 && flags_d[lprd_pkg::MF_SET]) begin
						res.command = lprd_pkg::CMD_SET;
					end
				end
				res_vld = 1'b1;
				phase_d = lprd_pkg::PH_OUTER;
				hpos_d  = 2'd0;
				mleft_d = '0;
				sleft_d = '0;
				total_d = '0;
				sbl_d   = '0;
				idx_d   = '0;
				flags_d = 4'hF;
				first_d = 1'b1;
			end else if (sl_new == 32'd0 || mleft_dec < MBW'(4)) begin
				res.message_end = 1'b1;
				res.status      = lprd_pkg::ST_BAD;
				res_vld         = 1'b1;
				phase_d         = lprd_pkg::PH_CLOSED;
			end else begin
				phase_d = lprd_pkg::PH_SLEN;
				hpos_d  = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lprd_pkg::PH_OUTER;
			hpos_q  <= 2'd0;
			hdr_q   <= '0;
			mleft_q <= '0;
			sleft_q <= '0;
			total_q <= '0;
			sbl_q   <= '0;
			idx_q   <= '0;
			flags_q <= 4'hF;
			first_q <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			hpos_q  <= hpos_d;
			hdr_q   <= hdr_d;
			mleft_q <= mleft_d;
			sleft_q <= sleft_d;
			total_q <= total_d;
			sbl_q   <= sbl_d;
			idx_q   <= idx_d;
			flags_q <= flags_d;
			first_q <= first_d;
		end
	end

endmodule

`default_nettype wire

>>> src/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer.
//
// Usage: raw connection bytes enter on the s_ stream, one byte per item in
// s_tdata. Each message is a 4-byte little-endian body length, a 4-byte
// string count, then the strings, each a 4-byte length and its bytes.
// Results leave on the m_ stream: every string byte with its string index,
// an empty-string mark, and at message end (m_tlast) the status, command
// class and string count. A byte and the message end it causes share one
// item; a header byte gives one only when it ends the message or a string.
// An accepted byte passes from the input register through the parse step
// into the result register, which drives m_, and one byte is accepted
// every cycle while the receiver does not stall, since each byte needs only
// counter and compare updates in the parse step between the two registers.
// When the receiver stalls, the result register holds its item and the
// input register holds one more byte; s_tready then falls.
// The cfg channel writes max_message_length; it is always ready and must
// only be written while the block is idle.
// Reset clears all framing state, sets the limit to 4096 and empties both
// registers. After a too-long or malformed message the block stays closed,
// taking and dropping bytes, until the next reset.
`default_nettype none

module length_prefixed_request_deframer #(
	parameter int unsigned MAX_BODY_BYTES = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,  // [7:0] data_byte
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [7:0] string_byte, [17:8] string_index, [18] string_done,
	// [20:19] status, [22:21] command, [32:23] string_count, [39:33] zero
	output logic [39:0]                     m_tdata,
	output logic                            m_tlast,  // message_end
	output logic                            m_tuser,  // [0] carries_byte
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lprd_pkg::CFG_W-1:0] cfg_data  // max_message_length
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        out_valid_q;
	lprd_pkg::result_t           out_q;
	logic [lprd_pkg::CFG_W-1:0]  max_len_q;
	logic                        out_free;
	logic                        step;
	lprd_pkg::result_t           res;
	logic                        res_vld;

	// The result register can take a new item when it is empty or draining.
	assign out_free  = !out_valid_q || m_tready;
	assign step      = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lprd_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// Input register: one byte waiting for the parse step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	lprd_core #(
		.MAX_BODY_BYTES(MAX_BODY_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_byte(byte_s1),
		.max_len  (max_len_q),
		.res      (res),
		.res_vld  (res_vld)
	);

	// Result register: holds the item until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_vld;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_vld) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.message_end;
	assign m_tuser  = out_q.carries_byte;
	assign m_tdata  = {7'd0, out_q.string_count, out_q.command, out_q.status,
		out_q.string_done, out_q.string_index, out_q.string_byte};

endmodule

`default_nettype wire

>>> src/lprd_checker.sv
// Port-level assertion checker of the deframer and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module lprd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);

	// A stalled result stays offered and unchanged.
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// An error status is only reported at message end, and code 3 never occurs.
	`ASSERT_IMPLY(a_status_end, clk, arst_n, m_tvalid && m_tdata[20:19] != 2'd0, m_tlast && m_tdata[20:19] != 2'd3, "status outside message end")

	// An item with no byte and no message end is an empty-string mark.
	`ASSERT_IMPLY(a_empty_mark, clk, arst_n, m_tvalid && !m_tuser && !m_tlast, m_tdata[18], "item without content")

	// Without a payload byte the byte field reads zero.
	`ASSERT_IMPLY(a_byte_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0, "stray byte value")

endmodule

bind length_prefixed_request_deframer lprd_checker u_lprd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

`default_nettype wire
